FILE: src/tcpts_pkg.sv
// Shared types and constants for the TCP timestamp option parser.
`default_nettype none
package tcpts_pkg;

  localparam int MAX_OPTIONS = 10;
  localparam int OPT_CNT_W   = $clog2(MAX_OPTIONS + 1);

  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] LEN_TS   = 8'd10;
  localparam logic [7:0] LEN_MIN  = 8'd2;

  localparam logic [2:0] TS_LAST_BYTE = 3'd7;

  typedef enum logic [2:0] {
    ST_FOUND  = 3'd0,
    ST_EOL    = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_BADLEN = 3'd3,
    ST_LIMIT  = 3'd4,
    ST_NOOPT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       end_of_options;
    logic       header_only;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] ts_value;
    logic [31:0] ts_echo_reply;
  } result_t;

endpackage
`default_nettype wire

FILE: src/tcpts_in_reg.sv
// Input register stage for option byte transfers.
`default_nettype none
module tcpts_in_reg
  import tcpts_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  item_valid,
  input  wire   item_take,
  output item_t item
);

  logic load_en;

  assign in_stall = item_valid && !item_take;
  assign load_en  = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load_en) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && in_valid) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/tcpts_walk.sv
// Option list walker: per-segment parse state and result formation.
`default_nettype none
module tcpts_walk
  import tcpts_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     item_valid,
  input  item_t   item,
  input  wire     out_free,
  output logic    item_take,
  output logic    res_load,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_KIND,
    PH_LEN,
    PH_SKIP,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  phase_t               phase, phase_next;
  logic [7:0]           skip_rem, skip_rem_next;
  logic [OPT_CNT_W-1:0] opt_seen, opt_seen_next;
  logic [7:0]           pend_kind, pend_kind_next;
  logic [63:0]          cap_buf, cap_buf_next;
  logic [2:0]           cap_cnt, cap_cnt_next;
  status_t              decided, decided_next;

  logic [OPT_CNT_W-1:0] seen_inc;
  logic                 at_limit;
  logic                 emit;
  logic [7:0]           b;

  assign b        = item.option_byte;
  assign seen_inc = opt_seen + OPT_CNT_W'(1);
  assign at_limit = seen_inc >= OPT_CNT_W'(MAX_OPTIONS);

  assign emit      = item.header_only || item.end_of_options;
  assign item_take = item_valid && (!emit || out_free);
  assign res_load  = item_valid && emit && out_free;

  always_comb begin
    phase_next     = phase;
    skip_rem_next  = skip_rem;
    opt_seen_next  = opt_seen;
    pend_kind_next = pend_kind;
    cap_buf_next   = cap_buf;
    cap_cnt_next   = cap_cnt;
    decided_next   = decided;
    case (phase)
      PH_KIND: begin
        if (b == KIND_EOL) begin
          phase_next   = PH_DONE;
          decided_next = ST_EOL;
        end else if (b == KIND_NOP) begin
          opt_seen_next = seen_inc;
          if (at_limit) begin
            phase_next   = PH_DONE;
            decided_next = ST_LIMIT;
          end
        end else begin
          pend_kind_next = b;
          phase_next     = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < LEN_MIN) begin
          phase_next   = PH_DONE;
          decided_next = ST_BADLEN;
        end else if (pend_kind == KIND_TS && b == LEN_TS) begin
          cap_cnt_next = 3'd0;
          phase_next   = PH_CAPTURE;
        end else begin
          skip_rem_next = b - LEN_MIN;
          opt_seen_next = seen_inc;
          phase_next    = (b == LEN_MIN) ? PH_KIND : PH_SKIP;
          if (at_limit) begin
            phase_next   = PH_DONE;
            decided_next = ST_LIMIT;
          end
        end
      end
      PH_SKIP: begin
        skip_rem_next = skip_rem - 8'd1;
        if (skip_rem == 8'd1) begin
          phase_next = PH_KIND;
        end
      end
      PH_CAPTURE: begin
        cap_buf_next = {cap_buf[55:0], b};
        cap_cnt_next = cap_cnt + 3'd1;
        if (cap_cnt == TS_LAST_BYTE) begin
          phase_next   = PH_DONE;
          decided_next = ST_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (item.header_only) begin
      res.status = ST_NOOPT;
    end else if (phase_next == PH_DONE) begin
      res.status = decided_next;
    end else begin
      res.status = ST_TRUNC;
    end
    if (res.status == ST_FOUND) begin
      res.ts_value      = cap_buf_next[63:32];
      res.ts_echo_reply = cap_buf_next[31:0];
    end else begin
      res.ts_value      = 32'd0;
      res.ts_echo_reply = 32'd0;
    end
  end

  // restart the walk after every emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_KIND;
      skip_rem  <= 8'd0;
      opt_seen  <= '0;
      pend_kind <= 8'd0;
      cap_cnt   <= 3'd0;
      decided   <= ST_TRUNC;
    end else if (item_take) begin
      if (emit) begin
        phase     <= PH_KIND;
        skip_rem  <= 8'd0;
        opt_seen  <= '0;
        pend_kind <= 8'd0;
        cap_cnt   <= 3'd0;
        decided   <= ST_TRUNC;
      end else begin
        phase     <= phase_next;
        skip_rem  <= skip_rem_next;
        opt_seen  <= opt_seen_next;
        pend_kind <= pend_kind_next;
        cap_cnt   <= cap_cnt_next;
        decided   <= decided_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cap_buf <= cap_buf_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/tcpts_out_reg.sv
// Result register stage holding one result until its transfer.
`default_nettype none
module tcpts_out_reg
  import tcpts_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     res_load,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  wire     out_stall,
  output result_t out_res
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/tcp_timestamp_option_parser_core.sv
// Top level of the TCP timestamp option parser.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    option_byte, end_of_options, header_only
//   out      source     out_valid/out_stall  status, ts_value, ts_echo_reply
//
// One option byte is taken per cycle while in_stall is low; a result is registered in the
// result register when the walker takes the byte that ends the segment from the input
// register. Reset clears the walk and both stage valids.
// A stalled result holds the walker only when the next byte also has a result.
`default_nettype none
module tcp_timestamp_option_parser_core
  import tcpts_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  option_byte,
  input  wire         end_of_options,
  input  wire         header_only,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  status,
  output logic [31:0] ts_value,
  output logic [31:0] ts_echo_reply
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t out_res;

  assign in_item.option_byte    = option_byte;
  assign in_item.end_of_options = end_of_options;
  assign in_item.header_only    = header_only;

  tcpts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  tcpts_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_load   (res_load),
    .res        (res)
  );

  tcpts_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status        = out_res.status;
  assign ts_value      = out_res.ts_value;
  assign ts_echo_reply = out_res.ts_echo_reply;

endmodule
`default_nettype wire

FILE: dv/tcpts_check_pkg.sv
// Expected-result tracking and comparison for the TCP timestamp option parser.
package tcpts_check_pkg;
  import tcpts_pkg::*;

  typedef enum {
    WALK_KIND,
    WALK_LEN,
    WALK_SKIP,
    WALK_CAPTURE,
    WALK_DONE
  } walk_phase_t;

  class ts_option_scoreboard;
    walk_phase_t phase;
    logic [7:0]  skip_left;
    logic [7:0]  kind_held;
    int          opts_walked;
    logic [63:0] ts_bytes;
    int          ts_count;
    bit          decided;
    status_t     verdict;

    result_t     expected_results[$];
    int          mismatches;
    int          transfers;
    int          bytes_walked;
    int          status_hits[8];

    function new();
      clear_walk();
    endfunction

    function void clear_walk();
      phase       = WALK_KIND;
      skip_left   = '0;
      kind_held   = '0;
      opts_walked = 0;
      ts_bytes    = '0;
      ts_count    = 0;
      decided     = 1'b0;
      verdict     = ST_TRUNC;
    endfunction

    function void settle(status_t st);
      verdict = st;
      decided = 1'b1;
      phase   = WALK_DONE;
    endfunction

    function void count_option();
      opts_walked++;
      if (opts_walked >= MAX_OPTIONS) settle(ST_LIMIT);
    endfunction

    function void walk_byte(logic [7:0] b);
      case (phase)
        WALK_KIND: begin
          if (b == KIND_EOL) settle(ST_EOL);
          else if (b == KIND_NOP) count_option();
          else begin
            kind_held = b;
            phase     = WALK_LEN;
          end
        end
        WALK_LEN: begin
          if (b < LEN_MIN) settle(ST_BADLEN);
          else if (kind_held == KIND_TS && b == LEN_TS) begin
            ts_bytes = '0;
            ts_count = 0;
            phase    = WALK_CAPTURE;
          end else begin
            skip_left = b - LEN_MIN;
            phase     = (skip_left == 0) ? WALK_KIND : WALK_SKIP;
            count_option();
          end
        end
        WALK_SKIP: begin
          skip_left--;
          if (skip_left == 0) phase = WALK_KIND;
        end
        WALK_CAPTURE: begin
          ts_bytes = {ts_bytes[55:0], b};
          ts_count++;
          if (ts_count >= 8) settle(ST_FOUND);
        end
        default: ;
      endcase
    endfunction

    function void note_transfer(logic [7:0] b, logic eoo, logic hdr);
      result_t r;
      transfers++;
      if (hdr) begin
        bytes_walked++;
        r.status        = ST_NOOPT;
        r.ts_value      = '0;
        r.ts_echo_reply = '0;
        expected_results.push_back(r);
        clear_walk();
        return;
      end
      if (!decided) begin
        bytes_walked++;
        walk_byte(b);
      end
      if (eoo) begin
        r.status        = decided ? verdict : ST_TRUNC;
        r.ts_value      = (r.status == ST_FOUND) ? ts_bytes[63:32] : 32'd0;
        r.ts_echo_reply = (r.status == ST_FOUND) ? ts_bytes[31:0] : 32'd0;
        expected_results.push_back(r);
        clear_walk();
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(logic [2:0] st, logic [31:0] tv, logic [31:0] te);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", st));
        return;
      end
      want = expected_results.pop_front();
      status_hits[want.status]++;
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (tv !== want.ts_value)
        report_mismatch($sformatf("ts_value %08h, want %08h", tv, want.ts_value));
      if (te !== want.ts_echo_reply)
        report_mismatch($sformatf("ts_echo_reply %08h, want %08h", te, want.ts_echo_reply));
    endtask
  endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench for the TCP timestamp option parser core.
module tb_top;
  import tcpts_pkg::*;
  import tcpts_check_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  option_byte;
  logic        end_of_options;
  logic        header_only;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [31:0] ts_value;
  logic [31:0] ts_echo_reply;

  ts_option_scoreboard sb;
  logic [7:0] seg[$];
  int  burst_left = 0;
  int  cycles = 0;
  bit  hold_req = 1'b0;

  tcp_timestamp_option_parser_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .option_byte   (option_byte),
    .end_of_options(end_of_options),
    .header_only   (header_only),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .ts_value      (ts_value),
    .ts_echo_reply (ts_echo_reply)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_transfer(option_byte, end_of_options, header_only);
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, ts_value, ts_echo_reply);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_results.size());
      $display("tcp_timestamp_option_parser_core test failed");
      $finish;
    end
  end

  initial begin
    int mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoo, input logic hdr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    option_byte    <= b;
    end_of_options <= eoo;
    header_only    <= hdr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_option();
    logic [7:0] k;
    logic [7:0] len;
    int r;
    case ($urandom_range(0, 5))
      0, 1: seg.push_back(KIND_NOP);
      2: begin
        seg.push_back(KIND_TS);
        seg.push_back(LEN_TS);
        repeat (8) seg.push_back(pick_byte());
      end
      default: begin
        k = 8'($urandom_range(2, 255));
        r = $urandom_range(0, 49);
        if (r == 0) len = 8'hFF;
        else if (r < 5) len = LEN_MIN;
        else len = 8'($urandom_range(3, 12));
        if (k == KIND_TS && len == LEN_TS) len = LEN_TS + 8'd1;
        seg.push_back(k);
        seg.push_back(len);
        repeat (int'(len) - 2) seg.push_back(pick_byte());
      end
    endcase
  endfunction

  task automatic send_segment();
    int  pick;
    int  cut;
    bit  hdr_seg;
    seg.delete();
    hdr_seg = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(0, 4)) add_option();
      if ($urandom_range(0, 2) == 0) begin
        seg.push_back(KIND_TS);
        seg.push_back(LEN_TS);
        repeat (8) seg.push_back(pick_byte());
      end
      if ($urandom_range(0, 3) == 0) begin
        seg.push_back(KIND_EOL);
        repeat ($urandom_range(0, 3)) seg.push_back(8'h00);
      end
      if (seg.size() == 0) seg.push_back(KIND_NOP);
      if (pick >= 55) begin
        cut = $urandom_range(0, seg.size() - 1);
        seg = seg[0:cut];
      end
    end else if (pick < 78) begin
      repeat ($urandom_range(0, 2)) add_option();
      seg.push_back(8'($urandom_range(2, 255)));
      seg.push_back(8'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) seg.push_back(pick_byte());
    end else if (pick < 86) begin
      repeat ($urandom_range(MAX_OPTIONS - 1, MAX_OPTIONS + 3)) begin
        if ($urandom_range(0, 1) == 0) seg.push_back(KIND_NOP);
        else begin
          cut = $urandom_range(2, 4);
          seg.push_back(8'($urandom_range(2, 255)));
          seg.push_back(8'(cut));
          repeat (cut - 2) seg.push_back(pick_byte());
        end
      end
      repeat ($urandom_range(0, 3)) seg.push_back(pick_byte());
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 16)) seg.push_back(pick_byte());
    end else begin
      hdr_seg = 1'b1;
      repeat ($urandom_range(0, 4)) seg.push_back(pick_byte());
    end
    foreach (seg[i]) send_item(seg[i], !hdr_seg && (i == seg.size() - 1), 1'b0);
    if (hdr_seg) send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin
    int  base;
    bit  paused;
    sb = new();
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    option_byte    <= 8'h00;
    end_of_options <= 1'b0;
    header_only    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_TS, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(KIND_EOL, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h05, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(KIND_TS, 1'b0, 1'b0);
    send_item(LEN_TS, 1'b0, 1'b0);
    repeat (4) send_item(8'hFF, 1'b0, 1'b0);
    repeat (3) send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'h1E, 1'b0, 1'b0);
    send_item(8'h04, 1'b1, 1'b0);
    repeat (MAX_OPTIONS - 1) send_item(KIND_NOP, 1'b0, 1'b0);
    send_item(8'hFE, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);

    hold_req = 1'b1;
    paused = 1'b0;
    base = sb.transfers;
    while (sb.transfers - base < RANDOM_ITEMS) begin
      send_segment();
      if (!paused && sb.transfers - base >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_results.size()));
    $display("Run covered %0d transfers (%0d bytes walked) in %0d cycles.",
             sb.transfers, sb.bytes_walked, cycles);
    $display({"Results: found %0d, end-of-list %0d, truncated %0d, ",
              "bad length %0d, limit %0d, none %0d"},
             sb.status_hits[ST_FOUND], sb.status_hits[ST_EOL], sb.status_hits[ST_TRUNC],
             sb.status_hits[ST_BADLEN], sb.status_hits[ST_LIMIT], sb.status_hits[ST_NOOPT]);
    if (sb.mismatches == 0)
      $display("tcp_timestamp_option_parser_core test passed");
    else
      $display("tcp_timestamp_option_parser_core test failed");
    $finish;
  end

endmodule
